// File: src/vnorm_pkg.sv
// shared types, constants and helpers of the vector normaliser
package vnorm_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int NUM_LANES     = 3;
    localparam int ROOT_STAGES   = 32;
    localparam int QUOT_W        = 31;
    localparam logic [39:0] TOL_RESET = 40'd2814749767;
    localparam logic [31:0] UNIT_ONE  = 32'h4000_0000;

    typedef enum logic [1:0] {
        CODE_UNIT   = 2'd0,
        CODE_ZERO   = 2'd1,
        CODE_SCALED = 2'd2
    } case_code_t;

    // side data travelling with the square root
    typedef struct packed {
        case_code_t                code;
        logic [NUM_LANES-1:0][31:0] pass;
        logic [NUM_LANES-1:0]       neg;
        logic [NUM_LANES-1:0][31:0] mag_c;
    } root_tag_t;

    // side data travelling with the divider
    typedef struct packed {
        case_code_t                code;
        logic [NUM_LANES-1:0][31:0] pass;
        logic [NUM_LANES-1:0]       neg;
        logic [31:0]                root;
    } div_tag_t;

    // magnitude of a two's complement word, full range
    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

// File: src/vec3_normalize.sv
// top level: unit vector and length of a signed 3-component vector
//
// Input stream s_*: one vector per word, x, y, z signed fixed point with
// FRAC_BITS fraction bits. Output stream m_*: unit x, y, z in Q2.30, the
// length with FRAC_BITS fraction bits, and in m_tuser the case code
// (already unit, near zero, scaled). tolerance_we/tolerance_wdata load the
// closeness band on the squared length; write it only while the block is
// empty.
// There are 70 register stages: five stages of magnitude, square, sum and
// band tests, 32 square root stages of one result bit each, 31 divider
// stages of one quotient bit each, a round stage and the output register.
// One vector enters per cycle while the output register is empty or taken.
// Reset clears every valid bit and loads the default tolerance.
// The whole pipeline advances together: when the output word is held by a
// stalled receiver, s_tready drops and every stage keeps its contents, so
// nothing is lost or repeated; with the output register empty or taken,
// the pipeline moves on every cycle.
module vec3_normalize #(
    parameter int FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // in_x, in_y, in_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // unit_x, unit_y, unit_z, magnitude
    output logic [1:0]   m_tuser,   // case_code
    input  logic         tolerance_we,
    input  logic [39:0]  tolerance_wdata
);

    localparam int L      = vnorm_pkg::NUM_LANES;
    localparam int UP_SH  = 30 - FRAC_BITS;
    localparam logic [63:0] L2_ONE  = 64'd1 << (2*FRAC_BITS);
    localparam logic [31:0] MAG_ONE = 32'd1 << FRAC_BITS;
    localparam int RTAG_W = $bits(vnorm_pkg::root_tag_t);
    localparam int DTAG_W = $bits(vnorm_pkg::div_tag_t);

    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // tolerance register
    logic [39:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= vnorm_pkg::TOL_RESET;
        else if (tolerance_we)
            tol_reg <= tolerance_wdata;
    end

    // stage 1: components and their magnitudes
    logic             v1_reg;
    logic [L-1:0][31:0] c1_reg, a1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < L; i++)
            begin
                c1_reg[i] <= s_tdata[32*i +: 32];
                a1_reg[i] <= vnorm_pkg::abs32(s_tdata[32*i +: 32]);
            end
        end
    end

    // stage 2: squares
    logic               v2_reg;
    logic [L-1:0][31:0] c2_reg, a2_reg;
    logic [L-1:0][63:0] sq2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < L; i++)
                sq2_reg[i] <= 64'(a1_reg[i]) * 64'(a1_reg[i]);
            c2_reg <= c1_reg;
            a2_reg <= a1_reg;
        end
    end

    // stage 3: squared length
    logic               v3_reg;
    logic [L-1:0][31:0] c3_reg, a3_reg;
    logic [63:0]        l2_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            c3_reg   <= c2_reg;
            a3_reg   <= a2_reg;
        end
    end

    // stage 4: distance from one, near-zero test
    logic               v4_reg;
    logic [L-1:0][31:0] c4_reg, a4_reg;
    logic [63:0]        l2_4_reg, diff4_reg;
    logic               near0_4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff4_reg   <= (l2_3_reg > L2_ONE) ? (l2_3_reg - L2_ONE) : (L2_ONE - l2_3_reg);
            near0_4_reg <= (l2_3_reg <= {24'd0, tol_reg});
            l2_4_reg    <= l2_3_reg;
            c4_reg      <= c3_reg;
            a4_reg      <= a3_reg;
        end
    end

    // stage 5: case decision and pass-through components
    logic               v5_reg;
    logic [63:0]        l2_5_reg;
    vnorm_pkg::root_tag_t rtag5_reg;
    vnorm_pkg::case_code_t code_next;
    logic [L-1:0][31:0] pass_next;
    logic [L-1:0]       neg_next;

    always_comb
    begin
        logic signed [63:0] ext;
        if (diff4_reg <= {24'd0, tol_reg})
            code_next = vnorm_pkg::CODE_UNIT;
        else if (near0_4_reg)
            code_next = vnorm_pkg::CODE_ZERO;
        else
            code_next = vnorm_pkg::CODE_SCALED;
        for (int i = 0; i < L; i++)
        begin
            ext = 64'(signed'(c4_reg[i])) <<< UP_SH;
            if (ext > 64'sd2147483647)
                pass_next[i] = 32'h7FFF_FFFF;
            else if (ext < -64'sd2147483648)
                pass_next[i] = 32'h8000_0000;
            else
                pass_next[i] = ext[31:0];
            neg_next[i] = c4_reg[i][31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_5_reg        <= l2_4_reg;
            rtag5_reg.code  <= code_next;
            rtag5_reg.pass  <= pass_next;
            rtag5_reg.neg   <= neg_next;
            rtag5_reg.mag_c <= a4_reg;
        end
    end

    // square root of the squared length
    logic                  root_valid;
    logic [31:0]           root;
    logic [RTAG_W-1:0]     root_tag_bits;
    vnorm_pkg::root_tag_t  root_tag;
    vnorm_pkg::div_tag_t   div_in_tag;

    vnorm_sqrt #(
        .TAG_W (RTAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_rad    (l2_5_reg),
        .in_tag    (rtag5_reg),
        .out_valid (root_valid),
        .out_root  (root),
        .out_tag   (root_tag_bits)
    );

    assign root_tag        = vnorm_pkg::root_tag_t'(root_tag_bits);
    assign div_in_tag.code = root_tag.code;
    assign div_in_tag.pass = root_tag.pass;
    assign div_in_tag.neg  = root_tag.neg;
    assign div_in_tag.root = root;

    // per-component quotient by the length
    logic                  div_valid;
    logic [L-1:0][30:0]    quot;
    logic [L-1:0]          rnd;
    logic [DTAG_W-1:0]     div_tag_bits;
    vnorm_pkg::div_tag_t   div_tag;

    vnorm_div #(
        .TAG_W (DTAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .in_a      (root_tag.mag_c),
        .in_d      (root),
        .in_tag    (div_in_tag),
        .out_valid (div_valid),
        .out_q     (quot),
        .out_rnd   (rnd),
        .out_tag   (div_tag_bits)
    );

    assign div_tag = vnorm_pkg::div_tag_t'(div_tag_bits);

    // output word: round, restore sign, select by case
    logic [L-1:0][31:0] unit_next;
    logic [31:0]        mag_next;
    logic [L-1:0][31:0] unit_reg;
    logic [31:0]        mag_reg;
    vnorm_pkg::case_code_t code_reg;

    always_comb
    begin
        logic [31:0] r;
        for (int i = 0; i < L; i++)
            unit_next[i] = '0;
        mag_next = '0;
        case (div_tag.code)
            vnorm_pkg::CODE_UNIT:
            begin
                unit_next = div_tag.pass;
                mag_next  = MAG_ONE;
            end
            vnorm_pkg::CODE_ZERO:
            begin
                unit_next[1] = vnorm_pkg::UNIT_ONE;
                mag_next     = '0;
            end
            default:
            begin
                for (int i = 0; i < L; i++)
                begin
                    r = {1'b0, quot[i]} + {31'd0, rnd[i]};
                    unit_next[i] = div_tag.neg[i] ? (~r + 32'd1) : r;
                end
                mag_next = div_tag.root;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg <= unit_next;
            mag_reg  <= mag_next;
            code_reg <= div_tag.code;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {mag_reg, unit_reg[2], unit_reg[1], unit_reg[0]};
    assign m_tuser  = code_reg;

endmodule

// File: src/vnorm_sqrt.sv
// pipelined truncating square root, one result bit per stage
module vnorm_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      in_rad,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output logic [TAG_W-1:0] out_tag
);

    localparam int N = vnorm_pkg::ROOT_STAGES;

    logic [63:0]      n_reg   [N];
    logic [63:0]      res_reg [N];
    logic [TAG_W-1:0] tag_reg [N];
    logic             v_reg   [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
            logic [63:0]      n_in, res_in, n_next, res_next, trial;
            logic [TAG_W-1:0] tag_in;
            logic             v_in;

            // previous stage or block input
            if (k == 0) begin : g_first
                assign n_in   = in_rad;
                assign res_in = 64'd0;
                assign tag_in = in_tag;
                assign v_in   = in_valid;
            end else begin : g_rest
                assign n_in   = n_reg[k-1];
                assign res_in = res_reg[k-1];
                assign tag_in = tag_reg[k-1];
                assign v_in   = v_reg[k-1];
            end

            // one restoring step
            always_comb
            begin
                trial = res_in + BIT;
                if (n_in >= trial)
                begin
                    n_next   = n_in - trial;
                    res_next = (res_in >> 1) + BIT;
                end
                else
                begin
                    n_next   = n_in;
                    res_next = res_in >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k]   <= n_next;
                    res_reg[k] <= res_next;
                    tag_reg[k] <= tag_in;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign out_root  = res_reg[N-1][31:0];
    assign out_tag   = tag_reg[N-1];

endmodule

// File: src/vnorm_div.sv
// three-lane pipelined divider of |c| * 2^30 by the length, with round flag
module vnorm_div #(
    parameter int TAG_W = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [vnorm_pkg::NUM_LANES-1:0][31:0] in_a,
    input  logic [31:0]                           in_d,
    input  logic [TAG_W-1:0]                      in_tag,
    output logic                                  out_valid,
    output logic [vnorm_pkg::NUM_LANES-1:0][30:0] out_q,
    output logic [vnorm_pkg::NUM_LANES-1:0]       out_rnd,
    output logic [TAG_W-1:0]                      out_tag
);

    localparam int N = vnorm_pkg::QUOT_W;
    localparam int L = vnorm_pkg::NUM_LANES;

    logic [31:0]      rem_reg [N][L];
    logic [N-1:0]     q_reg   [N][L];
    logic [31:0]      d_reg   [N];
    logic [TAG_W-1:0] tag_reg [N];
    logic             v_reg   [N];

    genvar k, l;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic [31:0]      d_in;
            logic [TAG_W-1:0] tag_in;
            logic             v_in;

            if (k == 0) begin : g_first
                assign d_in   = in_d;
                assign tag_in = in_tag;
                assign v_in   = in_valid;
            end else begin : g_rest
                assign d_in   = d_reg[k-1];
                assign tag_in = tag_reg[k-1];
                assign v_in   = v_reg[k-1];
            end

            for (l = 0; l < L; l++) begin : g_lane
                logic [32:0]  rem_in, diff;
                logic [N-1:0] q_in;
                logic         take;

                // first step sees the whole |c|, later ones shift in zeros
                if (k == 0) begin : g_first
                    assign rem_in = {1'b0, in_a[l]};
                    assign q_in   = '0;
                end else begin : g_rest
                    assign rem_in = {rem_reg[k-1][l], 1'b0};
                    assign q_in   = q_reg[k-1][l];
                end

                assign diff = rem_in - {1'b0, d_in};
                assign take = (rem_in >= {1'b0, d_in});

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k][l] <= take ? diff[31:0] : rem_in[31:0];
                        q_reg[k][l]   <= {q_in[N-2:0], take};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[k]   <= d_in;
                    tag_reg[k] <= tag_in;
                end
            end
        end
    endgenerate

    // round stage: half or more of the divisor left over rounds up
    logic             out_v_reg;
    logic [N-1:0]     out_q_reg   [L];
    logic [L-1:0]     out_rnd_reg;
    logic [TAG_W-1:0] out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= v_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < L; i++)
            begin
                out_q_reg[i]   <= q_reg[N-1][i];
                out_rnd_reg[i] <= ({rem_reg[N-1][i], 1'b0} >= {1'b0, d_reg[N-1]});
            end
            out_tag_reg <= tag_reg[N-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
            out_q[i] = out_q_reg[i];
    end

    assign out_valid = out_v_reg;
    assign out_rnd   = out_rnd_reg;
    assign out_tag   = out_tag_reg;

endmodule

// File: src/vnorm_check.sv
// port-level checker for the vector normaliser, bound to the top level
module vnorm_check #(
    parameter int FRAC_BITS = vnorm_pkg::FRAC_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [95:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         tolerance_we,
    input logic [39:0]  tolerance_wdata
);

    localparam logic [31:0] MAG_ONE = 32'd1 << FRAC_BITS;

    // a held output word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // input ready is high exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // near-zero word is the fixed up vector with zero length
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == vnorm_pkg::CODE_ZERO |->
            m_tdata[31:0] == 32'd0 && m_tdata[63:32] == vnorm_pkg::UNIT_ONE
            && m_tdata[95:64] == 32'd0 && m_tdata[127:96] == 32'd0)
        else $error("near-zero result is not the up vector");

    // pass-through word reports unit length
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == vnorm_pkg::CODE_UNIT |-> m_tdata[127:96] == MAG_ONE)
        else $error("pass-through result length is not one");

    // case code never takes the unused value
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined case code");

endmodule

bind vec3_normalize vnorm_check #(.FRAC_BITS(FRAC_BITS)) u_vnorm_check (.*);

// File: test/tb_vec3_normalize.sv
// self-checking testbench of the vector normaliser: predicted words against the output stream
`timescale 1ns / 1ps

module tb_vec3_normalize;

    localparam int FB = vnorm_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 70;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } vec_t;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [31:0] mag;
        vnorm_pkg::case_code_t code;
    } unit_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         tolerance_we;
    logic [39:0]  tolerance_wdata;

    vec_t  pending_vecs[$];
    unit_t expected_units[$];
    logic [39:0] tol_model;
    int    fail_count;
    bit    calm;
    bit    hold_off;
    bit    in_taken;
    int    src_gap;
    int    sink_gap;

    vec3_normalize dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .tolerance_we(tolerance_we), .tolerance_wdata(tolerance_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // integer square root, truncating
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // clamp to signed 32 bits
    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // normalise one vector as the block should
    function automatic unit_t normalise(input vec_t v);
        longint      c[3];
        logic [63:0] a;
        logic [63:0] len2;
        logic [63:0] one;
        logic [63:0] diff;
        logic [63:0] len;
        logic [95:0] num;
        logic [95:0] q;
        longint      u[3];
        unit_t       r;
        c[0] = longint'(signed'(v.x));
        c[1] = longint'(signed'(v.y));
        c[2] = longint'(signed'(v.z));
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = c[i] < 0 ? -c[i] : c[i];
            len2 = len2 + a * a;
        end
        one = 64'd1 << (2 * FB);
        diff = len2 > one ? len2 - one : one - len2;
        if (diff <= {24'd0, tol_model})
        begin
            r.code = vnorm_pkg::CODE_UNIT;
            for (int i = 0; i < 3; i++)
                u[i] = c[i] * (64'sd1 <<< (30 - FB));
            r.mag = 32'd1 << FB;
        end
        else if (len2 <= {24'd0, tol_model})
        begin
            r.code = vnorm_pkg::CODE_ZERO;
            u[0] = 0;
            u[1] = 64'sd1 <<< 30;
            u[2] = 0;
            r.mag = 0;
        end
        else
        begin
            r.code = vnorm_pkg::CODE_SCALED;
            len = root64(len2);
            if (len > 64'hffff_ffff)
                len = 64'hffff_ffff;
            r.mag = len[31:0];
            for (int i = 0; i < 3; i++)
            begin
                a = c[i] < 0 ? -c[i] : c[i];
                num = {32'd0, a} << 30;
                if (len == 0)
                    q = 0;
                else
                    q = (2 * num + len) / (2 * {32'd0, len});
                u[i] = c[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
            end
        end
        r.ux = clamp32(u[0]);
        r.uy = clamp32(u[1]);
        r.uz = clamp32(u[2]);
        return r;
    endfunction

    // source side: one word per handshake, random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
                ;
            else
            begin
                if (src_gap > 0 || hold_off || pending_vecs.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (src_gap > 0)
                        src_gap = src_gap - 1;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {pending_vecs[0].z, pending_vecs[0].y, pending_vecs[0].x};
                    expected_units.push_back(normalise(pending_vecs[0]));
                    void'(pending_vecs.pop_front());
                    if (!calm && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 11);
                end
            end
            // sink side stalls
            if (sink_gap > 0)
            begin
                m_tready <= 1'b0;
                sink_gap = sink_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 11);
            end
        end
    end

    // input handshake seen at the rising edge
    always @(posedge clk)
    begin
        in_taken = rst_n && s_tvalid && s_tready;
    end

    // output monitor
    always @(posedge clk)
    begin
        unit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_units.size() == 0)
            begin
                $error("output word with no expectation");
                fail_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (m_tdata[31:0] !== want.ux)
                begin
                    $error("unit_x expected %h actual %h", want.ux, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.uy)
                begin
                    $error("unit_y expected %h actual %h", want.uy, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== want.uz)
                begin
                    $error("unit_z expected %h actual %h", want.uz, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tdata[127:96] !== want.mag)
                begin
                    $error("magnitude expected %h actual %h", want.mag, m_tdata[127:96]);
                    fail_count++;
                end
                if (m_tuser !== want.code)
                begin
                    $error("case_code expected %0d actual %0d", want.code, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // random component, biased towards small magnitudes
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            2: return 32'(signed'($urandom_range(0, 32'h2000)) - 32'sh1000);
            default: return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hff00_0000;
        endcase
    endfunction

    // near-unit vector along one random axis
    function automatic vec_t near_unit(input int spread);
        vec_t v;
        logic [31:0] d;
        d = 32'(signed'($urandom_range(0, 2 * spread)) - spread);
        v.x = 0;
        v.y = 0;
        v.z = 0;
        case ($urandom_range(0, 2))
            0: v.x = 32'h0100_0000 + d;
            1: v.y = 32'hff00_0000 + d;
            default: v.z = 32'h0100_0000 + d;
        endcase
        return v;
    endfunction

    task automatic wait_idle();
        while (pending_vecs.size() != 0 || expected_units.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [39:0] t);
        @(negedge clk);
        tolerance_we <= 1'b1;
        tolerance_wdata <= t;
        tol_model = t;
        @(negedge clk);
        tolerance_we <= 1'b0;
    endtask

    task automatic load_random(input int n);
        vec_t v;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                v = near_unit($urandom_range(0, 64));
            else
            begin
                v.x = rand_comp();
                v.y = rand_comp();
                v.z = rand_comp();
            end
            pending_vecs.push_back(v);
        end
    endtask

    // stimulus
    initial
    begin
        logic [39:0] tols[5];
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        tolerance_we = 1'b0;
        tolerance_wdata = '0;
        fail_count = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        in_taken = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        tol_model = vnorm_pkg::TOL_RESET;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, unit, zero, scaled
        pending_vecs.push_back('{32'h0100_0000, 32'd0, 32'd0});
        pending_vecs.push_back('{32'd0, 32'hff00_0000, 32'd0});
        pending_vecs.push_back('{32'd0, 32'd0, 32'd0});
        pending_vecs.push_back('{32'd1, 32'hffff_ffff, 32'd1});
        pending_vecs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_vecs.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        pending_vecs.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'd0});
        pending_vecs.push_back('{32'h0300_0000, 32'h0400_0000, 32'd0});
        pending_vecs.push_back('{32'd0, 32'd0, 32'd1});
        pending_vecs.push_back('{32'h0100_0010, 32'd0, 32'd0});
        pending_vecs.push_back('{32'h0000_1000, 32'h0000_1000, 32'h0000_1000});
        pending_vecs.push_back('{32'h0093_cd3a, 32'h0093_cd3a, 32'h0093_cd3a});
        wait_idle();

        // tolerance zero, maximum, one, 2^24 and the reset value
        tols[0] = 40'd0;
        tols[1] = 40'hff_ffff_ffff;
        tols[2] = 40'd1;
        tols[3] = 40'h00_0100_0000;
        tols[4] = vnorm_pkg::TOL_RESET;
        for (int p = 0; p < 5; p++)
        begin
            set_tolerance(tols[p]);
            if (p == 1)
            begin
                pending_vecs.push_back('{32'h0100_0000, 32'd0, 32'd0});
                pending_vecs.push_back('{32'h7fff_ffff, 32'd0, 32'd0});
                pending_vecs.push_back('{32'h8000_0000, 32'h0000_1000, 32'd0});
                pending_vecs.push_back('{32'h0000_0010, 32'd0, 32'd0});
            end
            if (p == 4)
                calm = 1'b1;
            load_random(p == 4 ? 180 : 130);
            if (p == 2)
            begin
                // sender waits for the pipeline to drain mid-phase
                while (pending_vecs.size() > 60)
                    @(posedge clk);
                hold_off = 1'b1;
                while (expected_units.size() != 0 || s_tvalid)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("tb_vec3_normalize OK");
        else
            $display("tb_vec3_normalize NOT OK");
        $finish;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("tb_vec3_normalize NOT OK");
        $finish;
    end

endmodule

// File: vec3_normalize.f
src/vnorm_pkg.sv
src/vnorm_sqrt.sv
src/vnorm_div.sv
src/vec3_normalize.sv
src/vnorm_check.sv
test/tb_vec3_normalize.sv
